// ===== sv/dfwb_pkg.sv =====
package dfwb_pkg;

  // fixed field widths
  localparam int TAG_W      = 32;
  localparam int FPS_W      = 8;
  localparam int WLEN_W     = 5;
  localparam int SKIP_W     = 8;
  localparam int TGT_W      = 12;
  localparam int SLOT_OUT_W = 4;
  localparam int SKIPCNT_W  = 9;
  localparam int IVL_W      = 16;
  localparam int DIV_W      = 12;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [IVL_W-1:0] IvlMax = {IVL_W{1'b1}};

  // register map, word index
  typedef enum logic [1:0] {
    REG_WINDOW_LEN = 2'd0,
    REG_SKIP_COUNT = 2'd1,
    REG_TARGET_FPS = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ITEM_FRAME = 1'b0,
    ITEM_CLEAR = 1'b1
  } item_kind_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV_RATE,
    B_DIV_SKIP,
    B_UPDATE,
    B_DECIDE,
    B_EMIT_RD,
    B_EMIT_PUSH,
    B_EMPTY_PUSH
  } back_state_e;

  typedef struct packed {
    logic [WLEN_W-1:0] window_len;
    logic [SKIP_W-1:0] skip_count;
    logic [TGT_W-1:0]  target_fps_x16;
  } cfg_t;

  typedef struct packed {
    item_kind_e        kind;
    logic [TAG_W-1:0]  frame_tag;
    logic [FPS_W-1:0]  source_fps;
  } in_item_t;

  typedef struct packed {
    logic                  has_window;
    logic [TAG_W-1:0]      out_tag;
    logic [SLOT_OUT_W-1:0] slot_number;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== sv/dfwb_fifo.sv =====
module dfwb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LastPtr = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FullCnt = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/dfwb_div.sv =====
module dfwb_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfwb_pkg::div_req_t  req_i,
  output dfwb_pkg::div_rsp_t  rsp_o
);

  localparam int W     = dfwb_pkg::DIV_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [W:0]       shifted;
  logic             fits;

  // one restoring step per cycle
  assign shifted = {rem_q, quo_q[W-1]};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
      cnt_d = CNT_W'(W);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? W'(shifted - {1'b0, dvs_q}) : shifted[W-1:0];
      quo_d  = {quo_q[W-2:0], fits};
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== sv/dfwb_back.sv =====
module dfwb_back #(
  parameter int MAX_FRAMES = 16,
  parameter int TAG_BITS   = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dfwb_pkg::cfg_t      cfg_i,
  input  dfwb_pkg::in_item_t  item_i,
  input  logic                item_empty_i,
  output logic                item_pop_o,
  output dfwb_pkg::result_t   res_o,
  output logic                res_push_o,
  input  logic                res_full_i,
  output dfwb_pkg::div_req_t  div_req_o,
  input  dfwb_pkg::div_rsp_t  div_rsp_i
);

  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int FILL_W = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(MAX_FRAMES - 1);
  localparam logic [FILL_W-1:0] MaxFill  = FILL_W'(MAX_FRAMES);
  localparam logic [SUM_W-1:0]  SumMax   = SUM_W'(MAX_FRAMES);

  dfwb_pkg::back_state_e state_q, state_d;

  logic [TAG_BITS-1:0]            tag_mem_q [MAX_FRAMES];
  logic [TAG_BITS-1:0]            tag_q, tag_d, rd_data_q;
  logic [dfwb_pkg::IVL_W-1:0]     interval_q, interval_d, ic_q, ic_d;
  logic [dfwb_pkg::SKIPCNT_W-1:0] sc_q, sc_d;
  logic [SLOT_W-1:0]              ws_q, ws_d, idx_q, idx_d, slot_q, slot_d;
  logic [FILL_W-1:0]              fill_q, fill_d, fill_inc, len;
  logic                           accept_q, accept_d;
  logic                           mem_we, rd_en;
  logic [SLOT_W-1:0]              rd_addr, idx_next, start_idx;
  logic [SUM_W-1:0]               idx_sum;
  logic                           slot_last;

  // window length clamped to 1..MAX_FRAMES
  always_comb begin
    if (cfg_i.window_len == '0) begin
      len = FILL_W'(1);
    end else if (32'(cfg_i.window_len) > MAX_FRAMES) begin
      len = MaxFill;
    end else begin
      len = FILL_W'(cfg_i.window_len);
    end
  end

  // oldest held slot, ring arithmetic
  assign idx_sum   = SUM_W'(ws_q) + SumMax - SUM_W'(fill_q);
  assign start_idx = (idx_sum >= SumMax) ? SLOT_W'(idx_sum - SumMax) : SLOT_W'(idx_sum);
  assign idx_next  = (idx_q == LastSlot) ? '0 : idx_q + SLOT_W'(1);
  assign slot_last = (FILL_W'(slot_q) == len - FILL_W'(1));
  assign fill_inc  = (fill_q < MaxFill) ? fill_q + FILL_W'(1) : fill_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    tag_d      = tag_q;
    interval_d = interval_q;
    ic_d       = ic_q;
    sc_d       = sc_q;
    ws_d       = ws_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    fill_d     = fill_q;
    accept_d   = accept_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    div_req_o  = '0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    unique case (state_q)
      dfwb_pkg::B_IDLE: begin
        if (!item_empty_i) begin
          item_pop_o = 1'b1;
          if (item_i.kind == dfwb_pkg::ITEM_CLEAR) begin
            ws_d   = '0;
            fill_d = '0;
            sc_d   = '0;
            ic_d   = '0;
          end else begin
            tag_d              = TAG_BITS'(item_i.frame_tag);
            div_req_o.start    = 1'b1;
            div_req_o.dividend = {item_i.source_fps, 4'b0000};
            div_req_o.divisor  = cfg_i.target_fps_x16;
            state_d            = dfwb_pkg::B_DIV_RATE;
          end
        end
      end
      dfwb_pkg::B_DIV_RATE: begin
        if (div_rsp_i.done) begin
          if (cfg_i.target_fps_x16 == '0) begin
            interval_d = dfwb_pkg::IvlMax;
          end else if (div_rsp_i.quotient == '0) begin
            interval_d = dfwb_pkg::IVL_W'(1);
          end else begin
            interval_d = dfwb_pkg::IVL_W'(div_rsp_i.quotient);
          end
          // reuse the divider for the skip phase
          div_req_o.start    = 1'b1;
          div_req_o.dividend = dfwb_pkg::DIV_W'(sc_q);
          div_req_o.divisor  = dfwb_pkg::DIV_W'(cfg_i.skip_count) + dfwb_pkg::DIV_W'(1);
          state_d            = dfwb_pkg::B_DIV_SKIP;
        end
      end
      dfwb_pkg::B_DIV_SKIP: begin
        if (div_rsp_i.done) begin
          accept_d = (div_rsp_i.remainder == '0);
          state_d  = dfwb_pkg::B_UPDATE;
        end
      end
      dfwb_pkg::B_UPDATE: begin
        ic_d = (ic_q == dfwb_pkg::IvlMax) ? ic_q : ic_q + dfwb_pkg::IVL_W'(1);
        sc_d = (accept_q ? '0 : sc_q) + dfwb_pkg::SKIPCNT_W'(1);
        if (accept_q) begin
          mem_we = 1'b1;
          ws_d   = (ws_q == LastSlot) ? '0 : ws_q + SLOT_W'(1);
          fill_d = (fill_inc > len) ? fill_inc - FILL_W'(1) : fill_inc;
        end
        state_d = dfwb_pkg::B_DECIDE;
      end
      dfwb_pkg::B_DECIDE: begin
        if (fill_q >= len && ic_q >= interval_q) begin
          ic_d    = '0;
          idx_d   = start_idx;
          slot_d  = '0;
          state_d = dfwb_pkg::B_EMIT_RD;
        end else begin
          state_d = dfwb_pkg::B_EMPTY_PUSH;
        end
      end
      dfwb_pkg::B_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx_q;
        state_d = dfwb_pkg::B_EMIT_PUSH;
      end
      dfwb_pkg::B_EMIT_PUSH: begin
        res_o.has_window  = 1'b1;
        res_o.out_tag     = dfwb_pkg::TAG_W'(rd_data_q);
        res_o.slot_number = dfwb_pkg::SLOT_OUT_W'(slot_q);
        res_o.last        = slot_last;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (slot_last) begin
            state_d = dfwb_pkg::B_IDLE;
          end else begin
            // fetch the next entry while this one is pushed
            idx_d   = idx_next;
            slot_d  = slot_q + SLOT_W'(1);
            rd_en   = 1'b1;
            rd_addr = idx_next;
          end
        end
      end
      dfwb_pkg::B_EMPTY_PUSH: begin
        res_o.last = 1'b1;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = dfwb_pkg::B_IDLE;
        end
      end
      default: state_d = dfwb_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dfwb_pkg::B_IDLE;
      interval_q <= '0;
      ic_q       <= '0;
      sc_q       <= '0;
      ws_q       <= '0;
      idx_q      <= '0;
      slot_q     <= '0;
      fill_q     <= '0;
      accept_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      interval_q <= interval_d;
      ic_q       <= ic_d;
      sc_q       <= sc_d;
      ws_q       <= ws_d;
      idx_q      <= idx_d;
      slot_q     <= slot_d;
      fill_q     <= fill_d;
      accept_q   <= accept_d;
    end
  end

  // tag ring memory, registered read
  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    if (mem_we) begin
      tag_mem_q[ws_q] <= tag_q;
    end
    if (rd_en) begin
      rd_data_q <= tag_mem_q[rd_addr];
    end
  end

endmodule

// ===== sv/decimating_frame_window_buffer.sv =====
// channel   | handshake                | payload
// input     | push / full              | command_i, frame_tag_i, source_fps_i
// result    | empty / pop              | has_window_o, out_tag_o, slot_number_o, last_o
// config    | psel, penable, pwrite    | paddr, pwdata, prdata, pready
//
// a frame runs the rate division, the skip division, an update and a decide step,
// then emits its window entries or one empty result; the shared 12-step serial
// divider runs twice per frame (rate interval, then skip phase) and the tag memory
// read port yields one entry per cycle while the result queue is not full
// a two-entry queue on each side lets input and results stall on their own
// reset is asynchronous; the tag memory needs no clearing pass
module decimating_frame_window_buffer #(
  parameter int MAX_FRAMES = 16,
  parameter int TAG_BITS   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                command_i,
  input  logic [dfwb_pkg::TAG_W-1:0]          frame_tag_i,
  input  logic [dfwb_pkg::FPS_W-1:0]          source_fps_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                has_window_o,
  output logic [dfwb_pkg::TAG_W-1:0]          out_tag_o,
  output logic [dfwb_pkg::SLOT_OUT_W-1:0]     slot_number_o,
  output logic                                last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dfwb_pkg::ADDR_W-1:0]         paddr,
  input  logic [dfwb_pkg::DATA_W-1:0]         pwdata,
  output logic [dfwb_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int IN_W  = $bits(dfwb_pkg::in_item_t);
  localparam int RES_W = $bits(dfwb_pkg::result_t);

  dfwb_pkg::cfg_t      cfg;
  dfwb_pkg::in_item_t  in_item, head_item;
  dfwb_pkg::result_t   back_res, out_res;
  dfwb_pkg::div_req_t  div_req;
  dfwb_pkg::div_rsp_t  div_rsp;
  dfwb_pkg::reg_idx_e  reg_idx;
  logic [dfwb_pkg::WLEN_W-1:0] window_len_q;
  logic [dfwb_pkg::SKIP_W-1:0] skip_count_q;
  logic [dfwb_pkg::TGT_W-1:0]  target_fps_q;
  logic                        cfg_wr;
  logic                        item_empty, item_pop, res_push, res_full;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = dfwb_pkg::reg_idx_e'(paddr[dfwb_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= dfwb_pkg::WLEN_W'(16);
      skip_count_q <= '0;
      target_fps_q <= dfwb_pkg::TGT_W'(16);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dfwb_pkg::REG_WINDOW_LEN: window_len_q <= pwdata[dfwb_pkg::WLEN_W-1:0];
        dfwb_pkg::REG_SKIP_COUNT: skip_count_q <= pwdata[dfwb_pkg::SKIP_W-1:0];
        dfwb_pkg::REG_TARGET_FPS: target_fps_q <= pwdata[dfwb_pkg::TGT_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      dfwb_pkg::REG_WINDOW_LEN: prdata = dfwb_pkg::DATA_W'(window_len_q);
      dfwb_pkg::REG_SKIP_COUNT: prdata = dfwb_pkg::DATA_W'(skip_count_q);
      dfwb_pkg::REG_TARGET_FPS: prdata = dfwb_pkg::DATA_W'(target_fps_q);
      default:                  prdata = '0;
    endcase
  end

  assign cfg.window_len     = window_len_q;
  assign cfg.skip_count     = skip_count_q;
  assign cfg.target_fps_x16 = target_fps_q;

  // classify incoming transaction
  assign in_item.kind       = command_i ? dfwb_pkg::ITEM_CLEAR : dfwb_pkg::ITEM_FRAME;
  assign in_item.frame_tag  = frame_tag_i;
  assign in_item.source_fps = source_fps_i;

  dfwb_fifo #(
    .WIDTH (IN_W),
    .DEPTH (dfwb_pkg::QUEUE_DEPTH)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_item),
    .full_o  (full),
    .pop_i   (item_pop),
    .data_o  (head_item),
    .empty_o (item_empty)
  );

  dfwb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dfwb_back #(
    .MAX_FRAMES (MAX_FRAMES),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (head_item),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .res_o        (back_res),
    .res_push_o   (res_push),
    .res_full_i   (res_full),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp)
  );

  dfwb_fifo #(
    .WIDTH (RES_W),
    .DEPTH (dfwb_pkg::QUEUE_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign has_window_o  = out_res.has_window;
  assign out_tag_o     = out_res.out_tag;
  assign slot_number_o = out_res.slot_number;
  assign last_o        = out_res.last;

endmodule

// ===== sv/dfwb_checker.sv =====
module dfwb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            full,
  input logic                            empty,
  input logic                            pop,
  input logic                            has_window_o,
  input logic [dfwb_pkg::TAG_W-1:0]      out_tag_o,
  input logic [dfwb_pkg::SLOT_OUT_W-1:0] slot_number_o,
  input logic                            last_o
);

  // both queues come out of reset drained
  a_reset_queues: assert property (@(posedge clk_i) !rst_ni |-> empty && !full)
    else $error("queues not drained in reset");

  // an empty result carries a fixed pattern
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !has_window_o) |-> (last_o && out_tag_o == '0 && slot_number_o == '0))
    else $error("malformed empty result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_tag_o) && $stable(slot_number_o)
                          && $stable(last_o) && $stable(has_window_o)))
    else $error("stalled result changed");

  // window entries follow in slot order
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && has_window_o && !last_o) |=>
      (empty || (has_window_o &&
       slot_number_o == dfwb_pkg::SLOT_OUT_W'($past(slot_number_o) + 1'b1))))
    else $error("window entry out of order");

endmodule

bind decimating_frame_window_buffer dfwb_checker u_dfwb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .has_window_o  (has_window_o),
  .out_tag_o     (out_tag_o),
  .slot_number_o (slot_number_o),
  .last_o        (last_o)
);

// ===== test/testbench.sv =====
module testbench;

  localparam int SLOTS         = 16;
  localparam int SETTLE_CYCLES = 64;
  localparam int LONG_HOLD     = 600;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 38;
  localparam int PLAN_ROWS     = 36;
  localparam int AWAIT_DEPTH   = 256;
  // register index with no register behind it
  localparam int unsigned REG_UNUSED = 3;

  // short names for the plan table
  localparam dfwb_pkg::item_kind_e K_FRAME = dfwb_pkg::ITEM_FRAME;
  localparam dfwb_pkg::item_kind_e K_CLEAR = dfwb_pkg::ITEM_CLEAR;
  localparam int unsigned R_WLEN = dfwb_pkg::REG_WINDOW_LEN;
  localparam int unsigned R_SKIP = dfwb_pkg::REG_SKIP_COUNT;
  localparam int unsigned R_TGT  = dfwb_pkg::REG_TARGET_FPS;

  localparam dfwb_pkg::result_t NO_WINDOW = '{has_window: 1'b0, out_tag: '0,
                                              slot_number: '0, last: 1'b1};
  localparam dfwb_pkg::result_t ALL_ONES_ENTRY = '{has_window: 1'b1, out_tag: 32'hFFFF_FFFF,
                                                   slot_number: 4'd0, last: 1'b1};

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e            what;
    dfwb_pkg::item_kind_e kind;
    logic [31:0]          value;
    logic [7:0]           fps;
    int unsigned          reg_no;
    bit                   typed;
    dfwb_pkg::result_t    want;
  } plan_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            push;
  logic                            full;
  logic                            command_i;
  logic [dfwb_pkg::TAG_W-1:0]      frame_tag_i;
  logic [dfwb_pkg::FPS_W-1:0]      source_fps_i;
  logic                            empty;
  logic                            pop;
  logic                            has_window_o;
  logic [dfwb_pkg::TAG_W-1:0]      out_tag_o;
  logic [dfwb_pkg::SLOT_OUT_W-1:0] slot_number_o;
  logic                            last_o;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [dfwb_pkg::ADDR_W-1:0]     paddr;
  logic [dfwb_pkg::DATA_W-1:0]     pwdata;
  logic [dfwb_pkg::DATA_W-1:0]     prdata;
  logic                            pready;

  // window predictor state and its copy of the registers
  logic [dfwb_pkg::TAG_W-1:0] win_tags [SLOTS];
  int unsigned                wr_slot;
  int unsigned                fill;
  int unsigned                skip_cnt;
  int unsigned                ivl_cnt;
  dfwb_pkg::cfg_t             win_cfg;

  // expected results in order, ring with free-running counters
  dfwb_pkg::result_t awaited [AWAIT_DEPTH];
  int unsigned       awaited_wr;
  int unsigned       awaited_rd;
  plan_row_t         plan [PLAN_ROWS];

  bit calm;
  bit hold_request;
  int mismatches;
  int frames_sent;
  int clears_sent;
  int reg_writes;
  int entries_seen;
  int no_window_seen;
  int stall_cycles;

  decimating_frame_window_buffer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .frame_tag_i  (frame_tag_i),
    .source_fps_i (source_fps_i),
    .empty        (empty),
    .pop          (pop),
    .has_window_o (has_window_o),
    .out_tag_o    (out_tag_o),
    .slot_number_o(slot_number_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // append one expected transaction
  task automatic note_expected(input dfwb_pkg::result_t r);
    awaited[awaited_wr % AWAIT_DEPTH] = r;
    awaited_wr++;
  endtask

  // window predictor: one accepted transaction in, its window entries noted when record is set
  task automatic advance_window(input dfwb_pkg::item_kind_e kind,
                                input logic [dfwb_pkg::TAG_W-1:0] tag,
                                input logic [dfwb_pkg::FPS_W-1:0] fps, input bit record);
    int unsigned len;
    int unsigned ivl;
    int unsigned idx;
    dfwb_pkg::result_t r;
    len = win_cfg.window_len;
    if (len < 1) len = 1;
    if (len > SLOTS) len = SLOTS;
    if (kind == dfwb_pkg::ITEM_CLEAR) begin
      wr_slot  = 0;
      fill     = 0;
      skip_cnt = 0;
      ivl_cnt  = 0;
      return;
    end
    // output interval, zero target rate means the slowest interval
    if (win_cfg.target_fps_x16 == '0) begin
      ivl = 65535;
    end else begin
      ivl = (32'(fps) * 16) / 32'(win_cfg.target_fps_x16);
      if (ivl < 1) ivl = 1;
    end
    if (ivl_cnt < 65535) ivl_cnt++;
    // decimation: take one frame, then drop skip_count frames
    if (skip_cnt % (32'(win_cfg.skip_count) + 1) == 0) begin
      win_tags[wr_slot] = tag;
      wr_slot = (wr_slot + 1) % SLOTS;
      if (fill < SLOTS) fill++;
      if (fill > len) fill--;
      skip_cnt = 0;
    end
    skip_cnt = (skip_cnt + 1) & 32'h1FF;
    // emit the oldest len tags, or one empty entry
    if (fill >= len && ivl_cnt >= ivl) begin
      idx = (wr_slot + SLOTS - fill) % SLOTS;
      for (int unsigned i = 0; i < len; i++) begin
        r.has_window  = 1'b1;
        r.out_tag     = win_tags[idx];
        r.slot_number = i[dfwb_pkg::SLOT_OUT_W-1:0];
        r.last        = (i + 1 == len);
        if (record) note_expected(r);
        idx = (idx + 1) % SLOTS;
      end
      ivl_cnt = 0;
    end else begin
      if (record) note_expected(NO_WINDOW);
    end
  endtask

  // offer one transaction on the input side, with an occasional idle burst first
  task automatic offer_item(input dfwb_pkg::item_kind_e kind,
                            input logic [dfwb_pkg::TAG_W-1:0] tag,
                            input logic [dfwb_pkg::FPS_W-1:0] fps, input bit typed,
                            input dfwb_pkg::result_t want);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      push = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push         = 1'b1;
    command_i    = kind;
    frame_tag_i  = tag;
    source_fps_i = fps;
    @(posedge clk_i);
    while (full) begin
      stall_cycles++;
      @(posedge clk_i);
    end
    advance_window(kind, tag, fps, !typed);
    if (typed) note_expected(want);
    if (kind == dfwb_pkg::ITEM_CLEAR) clears_sent++;
    else frames_sent++;
  endtask

  // stop offering and let every expected entry drain
  task automatic drain_results();
    @(negedge clk_i);
    push = 1'b0;
    while (awaited_wr != awaited_rd) @(posedge clk_i);
  endtask

  // a clear leaves no entry behind, so wait out the block's latency as well
  task automatic settle_block();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // register write in setup and access phases, then read back if the register exists
  task automatic write_reg(input int unsigned idx, input logic [dfwb_pkg::DATA_W-1:0] wdata);
    logic [dfwb_pkg::DATA_W-1:0] stored;
    bit known;
    known = 1'b1;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = dfwb_pkg::ADDR_W'(idx * 4);
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    reg_writes++;
    case (idx)
      dfwb_pkg::REG_WINDOW_LEN: begin
        win_cfg.window_len = wdata[dfwb_pkg::WLEN_W-1:0];
        stored = dfwb_pkg::DATA_W'(wdata[dfwb_pkg::WLEN_W-1:0]);
      end
      dfwb_pkg::REG_SKIP_COUNT: begin
        win_cfg.skip_count = wdata[dfwb_pkg::SKIP_W-1:0];
        stored = dfwb_pkg::DATA_W'(wdata[dfwb_pkg::SKIP_W-1:0]);
      end
      dfwb_pkg::REG_TARGET_FPS: begin
        win_cfg.target_fps_x16 = wdata[dfwb_pkg::TGT_W-1:0];
        stored = dfwb_pkg::DATA_W'(wdata[dfwb_pkg::TGT_W-1:0]);
      end
      default: begin
        known  = 1'b0;
        stored = '0;
      end
    endcase
    if (known) begin
      @(negedge clk_i);
      psel    = 1'b1;
      penable = 1'b0;
      @(negedge clk_i);
      penable = 1'b1;
      @(posedge clk_i);
      while (!pready) @(posedge clk_i);
      if (prdata !== stored) begin
        $error("prdata: expected %0h, got %0h", stored, prdata);
        mismatches++;
      end
      @(negedge clk_i);
      psel    = 1'b0;
      penable = 1'b0;
    end
  endtask

  // result side: random pops, one long hold on request, field checks
  initial begin : result_side
    int stall_left;
    dfwb_pkg::result_t want;
    stall_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      pop = (stall_left == 0);
      if (stall_left > 0) stall_left--;
      @(posedge clk_i);
      if (pop && !empty) begin
        if (awaited_wr == awaited_rd) begin
          $error("unexpected transaction: has_window %0b tag %0h slot %0d last %0b",
                 has_window_o, out_tag_o, slot_number_o, last_o);
          mismatches++;
        end else begin
          want = awaited[awaited_rd % AWAIT_DEPTH];
          awaited_rd++;
          if (has_window_o !== want.has_window) begin
            $error("has_window: expected %0h, got %0h", want.has_window, has_window_o);
            mismatches++;
          end
          if (out_tag_o !== want.out_tag) begin
            $error("out_tag: expected %0h, got %0h", want.out_tag, out_tag_o);
            mismatches++;
          end
          if (slot_number_o !== want.slot_number) begin
            $error("slot_number: expected %0h, got %0h", want.slot_number, slot_number_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0h, got %0h", want.last, last_o);
            mismatches++;
          end
          if (want.has_window) entries_seen++;
          else no_window_seen++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    logic [dfwb_pkg::WLEN_W-1:0] wl;
    logic [dfwb_pkg::SKIP_W-1:0] sk;
    logic [dfwb_pkg::TGT_W-1:0]  tg;
    logic [dfwb_pkg::FPS_W-1:0]  fps;
    dfwb_pkg::item_kind_e        kind;

    rst_ni       = 1'b0;
    push         = 1'b0;
    command_i    = dfwb_pkg::ITEM_FRAME;
    frame_tag_i  = '0;
    source_fps_i = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    awaited_wr   = 0;
    awaited_rd   = 0;

    // predictor reset state
    foreach (win_tags[i]) win_tags[i] = '0;
    wr_slot  = 0;
    fill     = 0;
    skip_cnt = 0;
    ivl_cnt  = 0;
    win_cfg  = '{window_len: 5'd16, skip_count: 8'd0, target_fps_x16: 12'd16};

    // directed plan: extremes, clamping, zero rate, skipping, shortened window
    plan = '{
      '{ROW_ITEM, K_FRAME, 32'h0000_0000, 8'd0,   0,          1'b1, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'hFFFF_FFFF, 8'd255, 0,          1'b1, NO_WINDOW},
      '{ROW_ITEM, K_CLEAR, 32'hDEAD_BEEF, 8'd77,  0,          1'b0, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'd1,         8'd0,   R_WLEN,     1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'hFFFF_FFFF, 8'd0,   0,          1'b1, ALL_ONES_ENTRY},
      '{ROW_ITEM, K_FRAME, 32'h0000_0000, 8'd255, 0,          1'b1, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'd0,         8'd0,   R_TGT,      1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'hA5A5_A5A5, 8'd1,   0,          1'b1, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'hFFFF_FFFF, 8'd0,   R_TGT,      1'b0, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'd0,         8'd0,   R_WLEN,     1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h5A5A_5A5A, 8'd255, 0,          1'b0, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'hFFFF_FFFF, 8'd0,   R_WLEN,     1'b0, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'd255,       8'd0,   R_SKIP,     1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h0000_0001, 8'd128, 0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h0000_0002, 8'd64,  0,          1'b0, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'd2,         8'd0,   R_SKIP,     1'b0, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'd4,         8'd0,   R_WLEN,     1'b0, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'd16,        8'd0,   R_TGT,      1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0000, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0001, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0002, 8'd0,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0003, 8'd2,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0004, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0005, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0006, 8'd3,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0007, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0008, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h1000_0009, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'd2,         8'd0,   R_WLEN,     1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h2000_0001, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h2000_0002, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h2000_0003, 8'd1,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_CLEAR, 32'h0000_0000, 8'd0,   0,          1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h3000_0000, 8'd1,   0,          1'b1, NO_WINDOW},
      '{ROW_REG,  K_FRAME, 32'hFFFF_FFFF, 8'd0,   REG_UNUSED, 1'b0, NO_WINDOW},
      '{ROW_ITEM, K_FRAME, 32'h3000_0001, 8'd1,   0,          1'b0, NO_WINDOW}
    };

    // reset
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part
    foreach (plan[r]) begin
      if (plan[r].what == ROW_REG) begin
        settle_block();
        write_reg(plan[r].reg_no, plan[r].value);
      end else begin
        offer_item(plan[r].kind, plan[r].value, plan[r].fps, plan[r].typed, plan[r].want);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      case (ph)
        0: begin
          wl = 5'd16;
          sk = 8'd0;
          tg = 12'd4095;
        end
        1: begin
          wl = 5'd1;
          sk = 8'd255;
          tg = 12'd1;
        end
        default: begin
          wl = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
          sk = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
          case ($urandom_range(0, 4))
            0: tg = 12'd0;
            1: tg = 12'($urandom_range(1, 4095));
            2: tg = 12'd4095;
            default: tg = 12'($urandom_range(1024, 4095));
          endcase
        end
      endcase
      write_reg(dfwb_pkg::REG_WINDOW_LEN, {27'($urandom), wl});
      write_reg(dfwb_pkg::REG_SKIP_COUNT, {24'($urandom), sk});
      write_reg(dfwb_pkg::REG_TARGET_FPS, {20'($urandom), tg});
      if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, $urandom);
      // result side holds off while frames keep coming, so both queues fill
      if (ph == 2) hold_request = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == PHASES - 1 && k >= 12) calm = 1'b1;
        if (ph == 3 && k == 20) drain_results();
        kind = ($urandom_range(0, 29) == 0) ? dfwb_pkg::ITEM_CLEAR : dfwb_pkg::ITEM_FRAME;
        fps  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        offer_item(kind, $urandom, fps, 1'b0, NO_WINDOW);
      end
    end

    // wind down
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("sent %0d frames and %0d clears across %0d register writes",
             frames_sent, clears_sent, reg_writes);
    $display("checked %0d window entries and %0d empty results, input stalled %0d cycles",
             entries_seen, no_window_seen, stall_cycles);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
